@@ hw/rtl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high
`define ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ hw/rtl/isl_pkg.sv @@
// -----------------------------------------------------------------------------
// isl_pkg
// Widths, command and status codes, and shared types of the shift list.
// -----------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 64;
  localparam int FPOS_W  = 4;
  localparam int TOTAL_W = 5;
  localparam int STAT_W  = 2;

  // Stream bus widths, padded to whole bytes
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic              ins_en;
    logic              rem_en;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } cell_ctrl_t;

  // Partial result handed from the chain stage to the find stage
  typedef struct packed {
    logic               is_find;
    logic [WORD_W-1:0]  read_word;
    logic [TOTAL_W-1:0] total;
    logic [STAT_W-1:0]  status;
  } stage_t;

endpackage

`default_nettype wire

@@ hw/rtl/isl_cell.sv @@
// -----------------------------------------------------------------------------
// isl_cell
// One list slot: holds a word, takes it from a neighbor on insert or remove,
// and compares it with the broadcast search word.
// -----------------------------------------------------------------------------
`default_nettype none

module isl_cell
  import isl_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire                clk,
  input  cell_ctrl_t         ctrl,
  input  wire [WORD_W-1:0]   left_word,
  input  wire [WORD_W-1:0]   right_word,
  output logic [WORD_W-1:0]  word,
  output logic               hit
);

  // Shift up past the insert point, load at it, shift down from the remove point
  always_ff @(posedge clk) begin
    priority if (ctrl.ins_en && (INDEX > int'(ctrl.pos))) begin
      word <= left_word;
    end else if (ctrl.ins_en && (INDEX == int'(ctrl.pos))) begin
      word <= ctrl.word;
    end else if (ctrl.rem_en && (INDEX >= int'(ctrl.pos))) begin
      word <= right_word;
    end else begin
      word <= word;
    end
  end

  // Exact compare against the search word
  assign hit = (word == ctrl.word);

endmodule

`default_nettype wire

@@ hw/rtl/isl_find_stage.sv @@
// -----------------------------------------------------------------------------
// isl_find_stage
// Picks the highest matching slot, settles the find status and holds the
// result transaction until the master side takes it.
// -----------------------------------------------------------------------------
`default_nettype none

module isl_find_stage
  import isl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  stage_t                in_info,
  input  wire [CAPACITY-1:0]    hits,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // read_word, found_position, element_total
  output logic [STAT_W-1:0]     m_axis_tuser   // status
);

  logic [FPOS_W-1:0]  fpos;
  logic               any_hit;
  logic [WORD_W-1:0]  read_word;
  logic [FPOS_W-1:0]  found_position;
  logic [TOTAL_W-1:0] total;
  logic [STAT_W-1:0]  status;

  // Last set bit wins
  always_comb begin
    fpos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hits[i]) begin
        fpos = FPOS_W'(i);
      end
    end
  end

  assign any_hit  = |hits;
  assign in_ready = !m_axis_tvalid || m_axis_tready;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      read_word      <= in_info.read_word;
      found_position <= fpos;
      total          <= in_info.total;
      if (in_info.is_find) begin
        status <= any_hit ? ST_OK : ST_NOTFOUND;
      end else begin
        status <= in_info.status;
      end
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - WORD_W - FPOS_W - TOTAL_W)'(0),
                         total, found_position, read_word};
  assign m_axis_tuser = status;

endmodule

`default_nettype wire

@@ hw/rtl/indexed_shift_list.sv @@
// -----------------------------------------------------------------------------
// indexed_shift_list
// Ordered list of 64-bit words with read, insert, remove and find commands.
// -----------------------------------------------------------------------------
// One command transaction is taken every cycle while the result side keeps up;
// each result passes the chain stage register, then the find stage's output
// register. The list lives in a row of CAPACITY cells that all shift, load and
// compare in the cycle the command is accepted, so the next command sees the
// updated list at once; the registered find stage picks the highest matching
// cell for a find. Stored words need no clearing after reset: only slots below
// the element count are ever read, and reset empties the list at once.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module indexed_shift_list
  import isl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire [IN_DATA_W-1:0]   s_axis_tdata,  // position, data_word
  input  wire [CMD_W-1:0]       s_axis_tuser,  // command
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // read_word, found_position, element_total
  output logic [STAT_W-1:0]     m_axis_tuser   // status
);

  localparam int CW = $clog2(CAPACITY + 1);
  // Positions above the field range are never addressed by a read
  localparam int RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  logic               s_acc;
  logic [CMD_W-1:0]   cmd;
  logic [POS_W-1:0]   pos;
  logic [WORD_W-1:0]  in_word;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               pos_lt_cnt;
  logic               pos_gt_cnt;
  logic               is_full;
  logic               ins_ok;
  logic               rem_ok;
  logic [STAT_W-1:0]  status;
  logic [WORD_W-1:0]  rd_word;
  cell_ctrl_t         ctrl;
  logic [WORD_W-1:0]  cell_word [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  logic [CAPACITY-1:0] hit_vec;

  logic                st1_valid;
  logic                st1_ready;
  stage_t              st1;
  logic [CAPACITY-1:0] st1_hits;

  // Unpack the command transaction
  assign cmd     = s_axis_tuser;
  assign pos     = s_axis_tdata[POS_W-1:0];
  assign in_word = s_axis_tdata[POS_W+WORD_W-1:POS_W];

  assign s_axis_tready = !st1_valid || st1_ready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Range and capacity checks
  assign pos_lt_cnt = int'(pos) < int'(count);
  assign pos_gt_cnt = int'(pos) > int'(count);
  assign is_full    = int'(count) == CAPACITY;
  assign ins_ok     = (cmd == CMD_INSERT) && !pos_gt_cnt && !is_full;
  assign rem_ok     = (cmd == CMD_REMOVE) && pos_lt_cnt;

  always_comb begin
    unique case (cmd)
      CMD_READ:   status = pos_lt_cnt ? ST_OK : ST_RANGE;
      CMD_INSERT: status = pos_gt_cnt ? ST_RANGE : (is_full ? ST_FULL : ST_OK);
      CMD_REMOVE: status = pos_lt_cnt ? ST_OK : ST_RANGE;
      CMD_FIND:   status = ST_OK;
    endcase
  end

  // Track the element count
  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + 1'b1;
    end else if (rem_ok) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s_acc) begin
      count <= count_next;
    end
  end

  // Broadcast control to the chain
  assign ctrl.ins_en = s_acc && ins_ok;
  assign ctrl.rem_en = s_acc && rem_ok;
  assign ctrl.pos    = pos;
  assign ctrl.word   = in_word;

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = in_word;
    end else begin : g_inner_l
      assign left_word = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_word = cell_word[i];
    end else begin : g_inner_r
      assign right_word = cell_word[i+1];
    end

    isl_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (cell_word[i]),
      .hit        (cell_hit[i])
    );
  end

  // Select the addressed cell for a read
  always_comb begin
    rd_word = '0;
    if ((cmd == CMD_READ) && pos_lt_cnt) begin
      for (int i = 0; i < RD_N; i++) begin
        if (pos == POS_W'(i)) begin
          rd_word = rd_word | cell_word[i];
        end
      end
    end
  end

  // Keep only matches inside the list
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i] = cell_hit[i] && (i < int'(count)) && (cmd == CMD_FIND);
    end
  end

  // Register the chain stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      st1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      st1.is_find   <= (cmd == CMD_FIND);
      st1.read_word <= rd_word;
      st1.total     <= TOTAL_W'(count_next);
      st1.status    <= status;
      st1_hits      <= hit_vec;
    end
  end

  isl_find_stage #(
    .CAPACITY (CAPACITY)
  ) u_find (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (st1_valid),
    .in_ready      (st1_ready),
    .in_info       (st1),
    .hits          (st1_hits),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Checks on count bookkeeping and stage hand-off
  `ASSERT_ALWAYS(a_count_bound, clk, int'(count) <= CAPACITY, "element count above capacity")
  `ASSERT_CLK(a_insert_grows, clk, rst, (s_acc && ins_ok) |=> (int'(count) == int'($past(count)) + 1), "insert did not grow the list")
  `ASSERT_CLK(a_remove_shrinks, clk, rst, (s_acc && rem_ok) |=> (int'(count) == int'($past(count)) - 1), "remove did not shrink the list")
  `ASSERT_CLK(a_stage_hold, clk, rst, (st1_valid && !st1_ready) |=> st1_valid, "stalled chain stage lost its transaction")

endmodule

`default_nettype wire

@@ tb/sv/indexed_shift_list_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// indexed_shift_list_checker
// Watches both stream channels of the shift list, keeps its own copy of the
// list, works out the result of every accepted command and compares each
// returned result, field by field, with the oldest outstanding one.
// -----------------------------------------------------------------------------

module indexed_shift_list_checker
  import isl_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cmd_valid,
  input  wire                  cmd_ready,
  input  wire [IN_DATA_W-1:0]  cmd_data,    // position, data_word
  input  wire [CMD_W-1:0]      cmd_code,    // command
  input  wire                  rsp_valid,
  input  wire                  rsp_ready,
  input  wire [OUT_DATA_W-1:0] rsp_data,    // read_word, found_position, element_total
  input  wire [STAT_W-1:0]     rsp_status,  // status
  output int                   mismatch_count,
  output int                   pending_results,
  output int                   results_checked
);

  localparam int CAPACITY = CAPACITY_DEF;

  typedef struct packed {
    logic [WORD_W-1:0]  read_word;
    logic [FPOS_W-1:0]  found_position;
    logic [TOTAL_W-1:0] element_total;
    logic [STAT_W-1:0]  status;
  } list_result_t;

  logic [WORD_W-1:0] mirror_words [0:CAPACITY-1];
  int                mirror_count;
  list_result_t      awaited_results [$];

  // Apply one command to the mirrored list and return the result it yields
  function automatic list_result_t run_list_command(input logic [CMD_W-1:0]  cmd,
                                                    input logic [POS_W-1:0]  pos_bits,
                                                    input logic [WORD_W-1:0] word);
    list_result_t res;
    int           pos;
    int           k;
    logic         hit;
    res = '0;
    res.status = ST_OK;
    pos = int'(pos_bits);
    hit = 1'b0;
    case (cmd)
      CMD_READ: begin
        if (pos < mirror_count) res.read_word = mirror_words[pos];
        else res.status = ST_RANGE;
      end
      CMD_INSERT: begin
        if (pos > mirror_count) begin
          res.status = ST_RANGE;
        end else if (mirror_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // shift later words up to open the slot
          for (k = mirror_count; k > pos; k--) mirror_words[k] = mirror_words[k-1];
          mirror_words[pos] = word;
          mirror_count++;
        end
      end
      CMD_REMOVE: begin
        if (pos >= mirror_count) begin
          res.status = ST_RANGE;
        end else begin
          // close the gap by shifting later words down
          for (k = pos; k + 1 < mirror_count; k++) mirror_words[k] = mirror_words[k+1];
          mirror_count--;
        end
      end
      default: begin
        // keep the highest matching position
        for (k = 0; k < mirror_count; k++) begin
          if (mirror_words[k] == word) begin
            hit = 1'b1;
            res.found_position = k[FPOS_W-1:0];
          end
        end
        if (!hit) res.status = ST_NOTFOUND;
      end
    endcase
    res.element_total = mirror_count[TOTAL_W-1:0];
    return res;
  endfunction

  // Compare returned results and record the expectation of each new command
  always @(posedge clk) begin : watch_channels
    list_result_t want;
    list_result_t got;
    if (rst) begin
      mirror_count = 0;
      awaited_results.delete();
      mismatch_count = 0;
      results_checked = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        got.read_word      = rsp_data[WORD_W-1:0];
        got.found_position = rsp_data[WORD_W +: FPOS_W];
        got.element_total  = rsp_data[WORD_W+FPOS_W +: TOTAL_W];
        got.status         = rsp_status;
        if (awaited_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (got.read_word !== want.read_word) begin
            $error("read_word mismatch: expected %h, actual %h", want.read_word, got.read_word);
            mismatch_count++;
          end
          if (got.found_position !== want.found_position) begin
            $error("found_position mismatch: expected %0d, actual %0d",
                   want.found_position, got.found_position);
            mismatch_count++;
          end
          if (got.element_total !== want.element_total) begin
            $error("element_total mismatch: expected %0d, actual %0d",
                   want.element_total, got.element_total);
            mismatch_count++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            mismatch_count++;
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        awaited_results.push_back(run_list_command(cmd_code, cmd_data[POS_W-1:0],
                                                   cmd_data[POS_W +: WORD_W]));
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

@@ tb/sv/tb_indexed_shift_list.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_indexed_shift_list
// Drives read, insert, remove and find commands into the shift list: a directed
// pass over empty, full and out-of-range cases, then random command streams
// that fill and drain the list, the first with random stalls on both channels.
// -----------------------------------------------------------------------------

module tb_indexed_shift_list;
  import isl_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_BURST = 1000;
  localparam int RANDOM_CALM  = 300;
  localparam int PAD_W        = IN_DATA_W - POS_W - WORD_W;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = CMD_READ;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]     m_tuser;

  int mismatch_count;
  int pending_results;
  int results_checked;

  // Stimulus steering state
  int                list_fill  = 0;
  int                peak_fill  = 0;
  logic              growing    = 1'b1;
  logic              tx_gaps    = 1'b1;
  logic              rx_allowed = 1'b1;
  logic              rx_gaps    = 1'b1;
  int                rx_hold    = 0;
  int                quiet_cycles = 0;
  int                cmd_counts [0:3];
  logic [WORD_W-1:0] word_pool [0:7];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indexed_shift_list u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  indexed_shift_list_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (s_tvalid),
    .cmd_ready       (s_tready),
    .cmd_data        (s_tdata),
    .cmd_code        (s_tuser),
    .rsp_valid       (m_tvalid),
    .rsp_ready       (m_tready),
    .rsp_data        (m_tdata),
    .rsp_status      (m_tuser),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  // Stall the result side in random bursts while allowed
  always @(posedge clk) begin
    if (!rx_allowed) begin
      rx_gaps = 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      rx_gaps = !rx_gaps;
    end
    if (rst || !rx_gaps) begin
      rx_hold = 0;
    end else if (rx_hold == 0 && $urandom_range(0, 99) < 10) begin
      rx_hold = $urandom_range(1, 9);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [WORD_W-1:0] pick_word();
    if ($urandom_range(0, 99) < 60) return word_pool[$urandom_range(0, 7)];
    return {$urandom, $urandom};
  endfunction

  // Present one command and hold it until the block takes it
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                       input logic [WORD_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{PAD_W{1'b0}}, word, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cmd_counts[cmd]++;
    case (cmd)
      CMD_INSERT: if (pos <= list_fill && list_fill < CAPACITY) list_fill++;
      CMD_REMOVE: if (pos < list_fill) list_fill--;
      default: ;
    endcase
    if (list_fill > peak_fill) peak_fill = list_fill;
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic run_random(input int items);
    int                roll;
    int                pick;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    for (int i = 0; i < items; i++) begin
      if (list_fill >= CAPACITY) growing = 1'b0;
      else if (list_fill == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) < 2) growing = !growing;
      if ($urandom_range(0, 99) < 3) word_pool[$urandom_range(0, 7)] = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        // noise: any command at any encodable position
        cmd = CMD_W'($urandom_range(0, 3));
        pos = POS_W'($urandom_range(0, 31));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 20)      cmd = CMD_READ;
        else if (pick < 40) cmd = CMD_FIND;
        else if (pick < 85) cmd = growing ? CMD_INSERT : CMD_REMOVE;
        else                cmd = growing ? CMD_REMOVE : CMD_INSERT;
        if (cmd == CMD_INSERT) begin
          pos = ($urandom_range(0, 99) < 5) ? POS_W'(list_fill + 1)
                                            : POS_W'($urandom_range(0, list_fill));
        end else if (list_fill == 0 || $urandom_range(0, 99) < 5) begin
          pos = POS_W'(list_fill);
        end else begin
          pos = POS_W'($urandom_range(0, list_fill - 1));
        end
      end
      issue(cmd, pos, pick_word());
      // Toggle sender gaps only while idling is allowed
      if (rx_allowed && $urandom_range(0, 99) == 0) tx_gaps = !tx_gaps;
      if (tx_gaps && $urandom_range(0, 99) < 12) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) cmd_counts[i] = 0;
    word_pool[0] = '0;
    word_pool[1] = '1;
    for (int i = 2; i < 8; i++) word_pool[i] = {$urandom, $urandom};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: every command fails cleanly
    issue(CMD_READ,   5'd0,  '1);
    issue(CMD_REMOVE, 5'd0,  '0);
    issue(CMD_FIND,   5'd0,  '0);
    issue(CMD_INSERT, 5'd1,  '1);
    // Build a list with front, end and middle inserts and a duplicate
    issue(CMD_INSERT, 5'd0,  '1);
    issue(CMD_INSERT, 5'd1,  '0);
    issue(CMD_INSERT, 5'd0,  64'hA5A5_5A5A_F00D_CAFE);
    issue(CMD_INSERT, 5'd1,  64'h0123_4567_89AB_CDEF);
    issue(CMD_INSERT, 5'd4,  '1);
    issue(CMD_FIND,   5'd0,  '1);
    issue(CMD_FIND,   5'd31, 64'hFFFF_FFFF_FFFF_FFFE);
    // Fill to capacity, then try a full insert and out-of-range ones
    while (list_fill < CAPACITY) issue(CMD_INSERT, POS_W'(list_fill), {$urandom, $urandom});
    issue(CMD_INSERT, 5'd16, '1);
    issue(CMD_INSERT, 5'd17, '1);
    issue(CMD_INSERT, 5'd31, '0);
    issue(CMD_READ,   5'd15, '0);
    issue(CMD_READ,   5'd16, '0);
    issue(CMD_READ,   5'd31, '1);
    issue(CMD_FIND,   5'd0,  '0);
    issue(CMD_REMOVE, 5'd0,  '0);
    issue(CMD_REMOVE, 5'd14, '0);
    issue(CMD_REMOVE, 5'd20, '0);
    issue(CMD_REMOVE, 5'd31, '1);

    run_random(RANDOM_BURST);

    // Let the pipeline empty completely before the final stream
    wait_all_results();

    tx_gaps = 1'b0;
    rx_allowed = 1'b0;
    run_random(RANDOM_CALM);

    wait_all_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d reads, %0d inserts, %0d removes, %0d finds; %0d results checked.",
             cmd_counts[CMD_READ], cmd_counts[CMD_INSERT], cmd_counts[CMD_REMOVE],
             cmd_counts[CMD_FIND], results_checked);
    $display("List depth reached %0d of %0d, with stalls on both channels and a drained pause.",
             peak_fill, CAPACITY);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/isl_pkg.sv
hw/rtl/isl_cell.sv
hw/rtl/isl_find_stage.sv
hw/rtl/indexed_shift_list.sv
tb/sv/indexed_shift_list_checker.sv
tb/sv/tb_indexed_shift_list.sv
